// ===== sv/bounded_deque_macros.svh =====
// Assertion macros for the bounded deque checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define BDQ_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_deque: port check failed");

// Next-cycle implication, off while reset is high.
`define BDQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_deque: port check failed");

// Next-cycle implication that also covers reset itself.
`define BDQ_ASSERT_NEXT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bounded_deque: port check failed");

`endif

// ===== sv/bdq_pkg.sv =====
// Shared types and codes of the bounded deque.
// No dependencies; every other file but bdq_ram and the macro header imports it.
`default_nettype none

package bdq_pkg;

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] ST_ELEM  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE  = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [DATA_W-1:0]  value;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/bdq_in_if.sv =====
// Request channel of the bounded deque: one command item per handshake.
// Depends on bdq_pkg for field widths.
`default_nettype none

interface bdq_in_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

`default_nettype wire

// ===== sv/bdq_out_if.sv =====
// Response channel of the bounded deque: one result item per handshake.
// Depends on bdq_pkg for field widths.
`default_nettype none

interface bdq_out_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  element;
  logic [STAT_W-1:0]         status;
  logic                      last;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, element, status, last, occupancy, input ready);
  modport sink   (input valid, element, status, last, occupancy, output ready);
endinterface

`default_nettype wire

// ===== sv/bdq_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdq_front.sv =====
// Front end of the bounded deque: accepts request items and decodes them.
// Depends on bdq_pkg and bdq_in_if.
`default_nettype none

module bdq_front import bdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bdq_in_if.sink   req,
  output logic     op_valid,
  input  logic     op_ready,
  output op_t      op
);

  logic accept;

  function automatic op_t classify(input logic [CMD_W-1:0] cmd,
                                   input logic signed [DATA_W-1:0] value);
    op_t res;
    res.value = '0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        res.kind  = OP_PUSH_FRONT;
        res.value = value;
      end
      CMD_PUSH_BACK: begin
        res.kind  = OP_PUSH_BACK;
        res.value = value;
      end
      CMD_POP_FRONT: res.kind = OP_POP_FRONT;
      CMD_POP_BACK:  res.kind = OP_POP_BACK;
      CMD_DUMP:      res.kind = OP_DUMP;
      default:       res.kind = OP_NOP;
    endcase
    return res;
  endfunction

  assign req.ready = !op_valid || op_ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (accept) begin
        op_valid <= 1'b1;
        op       <= classify(req.cmd, req.value);
      end else if (op_ready) begin
        op_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdq_fifo.sv =====
// Short command queue between the front end and the execution back end.
// Depends on bdq_pkg.
`default_nettype none

module bdq_fifo import bdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  op_t           store [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_op     = store[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_SLOT) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_SLOT) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdq_back.sv =====
// Back end of the bounded deque: ring store, pointers, dump sequencer and
// the registered response stage. Depends on bdq_pkg, bdq_out_if and bdq_ram.
`default_nettype none

module bdq_back import bdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  op_t       op,
  bdq_out_if.source rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(DEPTH);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t                   state;
  logic [PTR_W-1:0]         front_idx;
  logic [CNT_W-1:0]         fill;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         issue_left;
  logic [CNT_W-1:0]         emit_left;
  logic                     rd_valid;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_element;
  logic [STAT_W-1:0]        out_status;
  logic                     out_last;
  logic [OCC_W-1:0]         out_occ;

  logic                     out_free;
  logic                     take;
  logic                     is_full;
  logic                     is_empty;
  logic [PTR_W-1:0]         front_dec;
  logic [PTR_W-1:0]         front_inc;
  logic [PTR_W:0]           back_sum;
  logic [PTR_W-1:0]         back_addr;
  logic [PTR_W-1:0]         rd_ptr_next;
  logic [CNT_W-1:0]         fill_inc;
  logic [CNT_W-1:0]         fill_dec;
  logic                     consume;
  logic                     re;
  logic                     we;
  logic [PTR_W-1:0]         waddr;
  logic [DATA_W-1:0]        rdata;

  assign out_free  = !out_valid || rsp.ready;
  assign op_ready  = (state == S_IDLE) && out_free;
  assign take      = op_valid && op_ready;
  assign is_full   = (fill == FULL_CNT);
  assign is_empty  = (fill == '0);
  assign fill_inc  = fill + CNT_W'(1);
  assign fill_dec  = fill - CNT_W'(1);
  assign front_dec = (front_idx == '0) ? LAST_PTR : front_idx - PTR_W'(1);
  assign front_inc = (front_idx == LAST_PTR) ? '0 : front_idx + PTR_W'(1);
  assign back_sum  = (PTR_W + 1)'(front_idx) + (PTR_W + 1)'(fill);
  assign back_addr = (back_sum >= DEPTH_W) ? PTR_W'(back_sum - DEPTH_W) : PTR_W'(back_sum);
  assign rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);

  assign consume = (state == S_DUMP) && rd_valid && out_free;
  assign re      = (state == S_DUMP) && (issue_left != '0) && (!rd_valid || consume);
  assign we      = take && !is_full &&
                   ((op.kind == OP_PUSH_FRONT) || (op.kind == OP_PUSH_BACK));
  assign waddr   = (op.kind == OP_PUSH_FRONT) ? front_dec : back_addr;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (op.value),
    .re    (re),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_idx <= '0;
      fill      <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            out_valid   <= 1'b1;
            out_element <= '0;
            out_last    <= 1'b1;
            out_status  <= ST_DONE;
            out_occ     <= OCC_W'(fill);
            case (op.kind)
              OP_PUSH_FRONT: begin
                if (is_full) begin
                  out_status <= ST_FULL;
                end else begin
                  front_idx <= front_dec;
                  fill      <= fill_inc;
                  out_occ   <= OCC_W'(fill_inc);
                end
              end
              OP_PUSH_BACK: begin
                if (is_full) begin
                  out_status <= ST_FULL;
                end else begin
                  fill    <= fill_inc;
                  out_occ <= OCC_W'(fill_inc);
                end
              end
              OP_POP_FRONT: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  front_idx <= front_inc;
                  fill      <= fill_dec;
                  out_occ   <= OCC_W'(fill_dec);
                end
              end
              OP_POP_BACK: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  fill    <= fill_dec;
                  out_occ <= OCC_W'(fill_dec);
                end
              end
              OP_DUMP: begin
                if (is_empty) begin
                  out_status <= ST_NONE;
                end else begin
                  out_valid  <= 1'b0;
                  state      <= S_DUMP;
                  rd_ptr     <= front_idx;
                  issue_left <= fill;
                  emit_left  <= fill;
                end
              end
              default: begin
                out_status <= ST_DONE;
              end
            endcase
          end
        end
        S_DUMP: begin
          if (re) begin
            rd_ptr     <= rd_ptr_next;
            issue_left <= issue_left - CNT_W'(1);
            rd_valid   <= 1'b1;
          end else if (consume) begin
            rd_valid <= 1'b0;
          end
          if (consume) begin
            out_valid   <= 1'b1;
            out_element <= $signed(rdata);
            out_status  <= ST_ELEM;
            out_last    <= (emit_left == CNT_W'(1));
            out_occ     <= OCC_W'(fill);
            emit_left   <= emit_left - CNT_W'(1);
            if (emit_left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.element   = out_element;
  assign rsp.status    = out_status;
  assign rsp.last      = out_last;
  assign rsp.occupancy = out_occ;

endmodule

`default_nettype wire

// ===== sv/bounded_deque.sv =====
// Bounded double-ended queue of signed 32-bit values, top level.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if, bdq_front, bdq_fifo, bdq_back.
//
// Requests arrive on req as valid/ready items carrying cmd and value:
// push front, push back, pop front, pop back or dump. Results leave on rsp
// as valid/ready items with element, status, last and occupancy. Every
// push, pop or unused code gives one result; a dump gives one result per
// stored element, front to back, with last on the final one, or a single
// empty-dump result.
// A request passes the decode register, the two-entry command queue and
// the execute stage that registers the result. Pushes and pops sustain one
// item per cycle while rsp.ready stays high. A dump holds the execute
// stage until its last element is emitted; the registered read port of
// the ring store delivers one element per cycle while rsp.ready stays high.
// Reset clears the pointers and the fill count, so the queue starts empty;
// the store needs no clearing. When the receiver holds rsp.ready low the
// result register holds, the execute stage waits, and the command queue
// and then req.ready back up behind it.
`default_nettype none

module bounded_deque import bdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  bdq_in_if.sink    req,
  bdq_out_if.source rsp
);

  logic dec_valid;
  logic dec_ready;
  op_t  dec_op;
  logic exe_valid;
  logic exe_ready;
  op_t  exe_op;

  bdq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (dec_valid),
    .op_ready (dec_ready),
    .op       (dec_op)
  );

  bdq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_op    (dec_op),
    .pop_valid  (exe_valid),
    .pop_ready  (exe_ready),
    .pop_op     (exe_op)
  );

  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (exe_valid),
    .op_ready (exe_ready),
    .op       (exe_op),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ===== sv/bounded_deque_checker.sv =====
// Port-level checks on the response channel of the bounded deque, with the
// bind that attaches them. Depends on bdq_pkg and bounded_deque_macros.svh.
`default_nettype none
`include "bounded_deque_macros.svh"

module bounded_deque_checker import bdq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic signed [DATA_W-1:0] element,
  input logic [STAT_W-1:0]        status,
  input logic                     last,
  input logic [OCC_W-1:0]         occupancy
);

  `BDQ_ASSERT_NEXT_ALWAYS(a_quiet_after_reset, rst, !rsp_valid)
  `BDQ_ASSERT_IMPL(a_occ_bound, rsp_valid, occupancy <= OCC_W'(DEPTH))
  `BDQ_ASSERT_IMPL(a_single_result, rsp_valid && status != ST_ELEM, element == '0 && last)
  `BDQ_ASSERT_IMPL(a_dump_nonempty, rsp_valid && status == ST_ELEM, occupancy != '0)
  `BDQ_ASSERT_NEXT(a_hold_on_stall, rsp_valid && !rsp_ready, rsp_valid && $stable(element) && $stable(status) && $stable(last) && $stable(occupancy))

endmodule

bind bounded_deque bounded_deque_checker #(
  .DEPTH (DEPTH)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .element   (rsp.element),
  .status    (rsp.status),
  .last      (rsp.last),
  .occupancy (rsp.occupancy)
);

`default_nettype wire

// ===== tb/bounded_deque_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bounded double-ended queue.
// Mirrors the ring store in a small class, checks every result item and
// depends on bdq_pkg, bdq_in_if, bdq_out_if and bounded_deque.

module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int REPORT_LIMIT = 10;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct {
    logic signed [DATA_W-1:0] element;
    logic [STAT_W-1:0]        status;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  class deque_shadow;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int front_idx;
    int fill;
    deque_result_t awaited [$];
    int mismatches;

    function new();
      front_idx = 0;
      fill = 0;
      mismatches = 0;
    endfunction

    function void add_result(logic signed [DATA_W-1:0] element, logic [STAT_W-1:0] status,
                             logic last);
      deque_result_t r;
      r.element = element;
      r.status = status;
      r.last = last;
      r.occupancy = OCC_W'(fill);
      awaited.push_back(r);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            add_result('0, ST_FULL, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              front_idx = (front_idx + DEPTH - 1) % DEPTH;
              slots[front_idx] = value;
            end else begin
              slots[(front_idx + fill) % DEPTH] = value;
            end
            fill++;
            add_result('0, ST_DONE, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (fill == 0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              front_idx = (front_idx + 1) % DEPTH;
            end
            fill--;
            add_result('0, ST_DONE, 1'b1);
          end
        end
        CMD_DUMP: begin
          if (fill == 0) begin
            add_result('0, ST_NONE, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              add_result(slots[(front_idx + i) % DEPTH], ST_ELEM, i == fill - 1);
            end
          end
        end
        default: begin
          add_result('0, ST_DONE, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic signed [DATA_W-1:0] element, logic [STAT_W-1:0] status,
                               logic last, logic [OCC_W-1:0] occupancy);
      deque_result_t want;
      if (awaited.size() == 0) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("unexpected result: element %0d status %0d last %0b occupancy %0d",
                   element, status, last, occupancy);
        end
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (element !== want.element || status !== want.status || last !== want.last ||
          occupancy !== want.occupancy) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("result mismatch: expected element %0d status %0d last %0b occupancy %0d",
                   want.element, want.status, want.last, want.occupancy);
          $display("                 got      element %0d status %0d last %0b occupancy %0d",
                   element, status, last, occupancy);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  bdq_in_if  req ();
  bdq_out_if rsp ();

  bounded_deque #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  deque_shadow deque_state = new();
  int send_idle_pct;
  int recv_stall_pct;
  int stim_fill;
  int full_hits;
  int empty_hits;
  bit growing;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        deque_state.check_result(rsp.element, rsp.status, rsp.last, rsp.occupancy);
      end
      if (req.valid && req.ready) begin
        deque_state.note_command(req.cmd, req.value);
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (stim_fill < DEPTH) stim_fill++;
        else full_hits++;
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (stim_fill > 0) stim_fill--;
        else empty_hits++;
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // The mix swings between filling the queue until pushes bounce off a full
  // store and draining it until pops hit an empty one.
  task automatic send_random();
    logic [CMD_W-1:0] cmd;
    int r;
    if (growing && stim_fill == DEPTH && full_hits >= 3) begin
      growing = 1'b0;
      empty_hits = 0;
    end else if (!growing && stim_fill == 0 && empty_hits >= 2) begin
      growing = 1'b1;
      full_hits = 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      cmd = CMD_W'(CMD_DUMP + 1 + $urandom_range(CMD_LAST_CODE - CMD_DUMP - 1));
    end else if (r < 8) begin
      cmd = CMD_DUMP;
    end else if ((r < 88) == growing) begin
      cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else begin
      cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    end
    send_item(cmd, pick_value());
  endtask

  initial begin
    req.valid <= 1'b0;
    req.cmd <= CMD_PUSH_FRONT;
    req.value <= '0;
    rst <= 1'b1;
    send_idle_pct = 28;
    recv_stall_pct = 72;
    stim_fill = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_DUMP, pick_value());
    send_item(CMD_POP_FRONT, pick_value());
    send_item(CMD_POP_BACK, pick_value());
    send_item(CMD_PUSH_BACK, VALUE_MAX);
    send_item(CMD_PUSH_FRONT, VALUE_MIN);
    send_item(CMD_PUSH_BACK, '0);
    send_item(CMD_PUSH_FRONT, '1);
    send_item(CMD_DUMP, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_BACK, '0);
    send_item(CMD_DUMP, '0);
    for (int c = CMD_DUMP + 1; c <= CMD_LAST_CODE; c++) begin
      send_item(CMD_W'(c), pick_value());
    end
    send_item(CMD_PUSH_BACK, 32'sh5555_5555);
    send_item(CMD_PUSH_FRONT, 32'shAAAA_AAAA);
    send_item(CMD_DUMP, '0);
    repeat (5) send_item(CMD_POP_BACK, pick_value());
    send_item(CMD_DUMP, '0);

    growing = 1'b1;
    full_hits = 0;
    empty_hits = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_stall_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_stall_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random();
    end
    req.valid <= 1'b0;
    @(posedge clk);

    while (deque_state.pending() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (deque_state.mismatches == 0 && deque_state.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== bounded_deque.f =====
+incdir+sv
sv/bdq_pkg.sv
sv/bdq_in_if.sv
sv/bdq_out_if.sv
sv/bdq_ram.sv
sv/bdq_front.sv
sv/bdq_fifo.sv
sv/bdq_back.sv
sv/bounded_deque.sv
sv/bounded_deque_checker.sv
tb/bounded_deque_tb.sv
